[sv/hafmp_pkg.sv]
`timescale 1ns / 1ps

package hafmp_pkg;

   // sample format
   localparam int SMP_WIDTH = 16;
   localparam logic [15:0] SMP_MAX = 16'h7FFF;
   localparam logic [15:0] SMP_MIN = 16'h8000;

   // mu-law encoder constants
   localparam logic [16:0] MU_CLIP = 17'd32635;
   localparam logic [14:0] MU_BIAS = 15'h084;

   // coefficient register width, Q0.x unsigned
   localparam int COEFF_WIDTH = 16;

   // frame selection limits
   localparam logic [6:0] DECIM_MAX = 7'd64;

   // queue depths
   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   // results that may still be in flight when the engine takes a new frame
   localparam int RSP_RESERVE = 1;

   // register reset values
   localparam logic [15:0] LOWPASS_COEFF_RESET  = 16'd2075;
   localparam logic [15:0] HIGHPASS_COEFF_RESET = 16'd51937;
   localparam logic [6:0]  DECIMATION_RESET     = 7'd12;
   localparam logic [4:0]  CHUNK_PAIRS_RESET    = 5'd31;

   // register map, one word per register
   typedef enum logic [1:0] {
      REG_LOWPASS_COEFF  = 2'd0,
      REG_HIGHPASS_COEFF = 2'd1,
      REG_DECIMATION     = 2'd2,
      REG_CHUNK_PAIRS    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [15:0] lowpass_coeff;
      logic [15:0] highpass_coeff;
      logic [6:0]  decimation;
      logic [4:0]  chunk_pairs;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] front_right_sample;
      logic signed [15:0] rear_left_sample;
      logic signed [15:0] rear_right_sample;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] left_code;
      logic [7:0] right_code;
      logic       chunk_end;
   } rsp_payload_type;

   // classified frame passed from front to back
   typedef struct packed {
      req_payload_type samples;
      logic            keep;
      logic            chunk_end;
   } frame_item_type;

   // which filter a product in flight belongs to
   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_HP    = 2'd1,
      OP_LEFT  = 2'd2,
      OP_RIGHT = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        keep;
      logic        chunk_end;
   } op_tag_type;

   // multiplier issue sequencer
   typedef enum logic [1:0] {
      PH_HP    = 2'd0,
      PH_LEFT  = 2'd1,
      PH_RIGHT = 2'd2
   } phase_type;

endpackage

[sv/hafmp_fifo.sv]
`timescale 1ns / 1ps

module hafmp_fifo #(
   parameter int WIDTH   = 8,
   parameter int DEPTH   = 4,
   parameter int RESERVE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_HIGH = CNT_W'(DEPTH - RESERVE);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // full rises while fewer than RESERVE + 1 entries are free; a push still
   // lands while any entry is free, so beats already in flight drain into the reserve
   assign full     = (count_ff >= CNT_HIGH);
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && (count_ff != CNT_FULL);
   assign do_pop   = pop && !empty;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/hafmp_front.sv]
`timescale 1ns / 1ps

module hafmp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  hafmp_pkg::cfg_type         cfg,
   input  logic                       req_push,
   input  hafmp_pkg::req_payload_type req_payload,
   output logic                       req_full,
   input  logic                       mid_full,
   output logic                       mid_push,
   output hafmp_pkg::frame_item_type  mid_item
);

   import hafmp_pkg::*;

   logic [5:0] decim_phase_ff, decim_phase_in;
   logic [4:0] pair_count_ff, pair_count_in;
   logic [6:0] decim_eff;
   logic [6:0] phase_next;
   logic [4:0] chunk_eff;
   logic [5:0] pair_next;
   logic       keep;
   logic       chunk_done;

   assign req_full = mid_full;
   assign mid_push = req_push && !mid_full;

   // effective limits: zero acts as one, decimation saturates
   always_comb begin
      if (cfg.decimation == '0) begin
         decim_eff = 7'd1;
      end else if (cfg.decimation > DECIM_MAX) begin
         decim_eff = DECIM_MAX;
      end else begin
         decim_eff = cfg.decimation;
      end
      chunk_eff = (cfg.chunk_pairs == '0) ? 5'd1 : cfg.chunk_pairs;
   end

   // frame keep decision and chunk marking
   always_comb begin
      keep       = (decim_phase_ff == '0);
      phase_next = {1'b0, decim_phase_ff} + 7'd1;
      pair_next  = {1'b0, pair_count_ff} + 6'd1;
      chunk_done = (pair_next >= {1'b0, chunk_eff});

      decim_phase_in = decim_phase_ff;
      pair_count_in  = pair_count_ff;
      if (mid_push) begin
         decim_phase_in = (phase_next >= decim_eff) ? '0 : phase_next[5:0];
         if (keep) begin
            pair_count_in = chunk_done ? '0 : pair_next[4:0];
         end
      end

      mid_item.samples   = req_payload;
      mid_item.keep      = keep;
      mid_item.chunk_end = keep && chunk_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decim_phase_ff <= '0;
         pair_count_ff  <= '0;
      end else begin
         decim_phase_ff <= decim_phase_in;
         pair_count_ff  <= pair_count_in;
      end
   end

endmodule

[sv/hafmp_back.sv]
`timescale 1ns / 1ps

module hafmp_back #(
   parameter int COEFF_FRAC_BITS = 16,
   parameter int STATE_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hafmp_pkg::cfg_type         cfg,
   input  logic                       mid_empty,
   input  hafmp_pkg::frame_item_type  mid_item,
   output logic                       mid_pop,
   input  logic                       rsp_room,
   output logic                       rsp_push,
   output hafmp_pkg::rsp_payload_type rsp_item
);

   import hafmp_pkg::*;

   localparam int S     = STATE_FRAC_BITS;
   localparam int ACC_W = SMP_WIDTH + S;
   localparam int OPD_W = ACC_W + 2;
   localparam int PRD_W = OPD_W + COEFF_WIDTH + 1;
   localparam int SUM_W = PRD_W + 1;
   localparam logic signed [SUM_W-1:0] ACC_HI = {{(SUM_W - ACC_W){1'b0}}, SMP_MAX, {S{1'b0}}};
   localparam logic signed [SUM_W-1:0] ACC_LO = {{(SUM_W - ACC_W){1'b1}}, SMP_MIN, {S{1'b0}}};

   // fixed point state to integer, truncating toward zero
   function automatic logic signed [15:0] acc_to_int(input logic signed [ACC_W-1:0] acc);
      logic signed [15:0] whole;
      logic               frac_nz;
      whole   = acc[ACC_W-1:S];
      frac_nz = |acc[S-1:0];
      return whole + 16'(acc[ACC_W-1] && frac_nz);
   endfunction

   // 16 bit saturating add
   function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
      logic [16:0] sum;
      sum = {a[15], a} + {b[15], b};
      if (sum[16] != sum[15]) begin
         return sum[16] ? SMP_MIN : SMP_MAX;
      end
      return sum[15:0];
   endfunction

   // g.711 mu-law compression of one sample
   function automatic logic [7:0] mulaw_encode(input logic signed [15:0] smp);
      logic [16:0] mag;
      logic [14:0] biased;
      logic [7:0]  seg;
      logic [2:0]  expo;
      logic [14:0] shifted;
      mag = smp[15] ? (17'd0 - {smp[15], smp}) : {1'b0, smp};
      if (mag > MU_CLIP) begin
         mag = MU_CLIP;
      end
      biased = mag[14:0] + MU_BIAS;
      seg    = biased[14:7];
      expo   = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (seg[i]) begin
            expo = 3'(i);
         end
      end
      shifted = biased >> ({1'b0, expo} + 4'd3);
      return ~{smp[15], expo, shifted[3:0]};
   endfunction

   phase_type               phase_ff, phase_in;
   frame_item_type          item_ff;
   logic signed [ACC_W-1:0] hp_acc_ff;
   logic signed [ACC_W-1:0] lpl_acc_ff;
   logic signed [ACC_W-1:0] lpr_acc_ff;
   logic signed [15:0]      last_in_ff;

   logic signed [OPD_W-1:0] opd_ff, opd_in;
   logic [COEFF_WIDTH-1:0]  coef_ff, coef_in;
   op_tag_type              opd_tag_ff, opd_tag_in;
   logic signed [PRD_W-1:0] prd_ff, prd_in;
   op_tag_type              prd_tag_ff;

   logic                    fin_valid_ff;
   logic                    fin_chunk_end_ff;
   logic signed [15:0]      fin_hp_ff;
   logic signed [15:0]      fin_l_ff;

   logic signed [16:0]      hp_diff;
   logic signed [OPD_W-1:0] opd_hp;
   logic signed [OPD_W-1:0] opd_left;
   logic signed [OPD_W-1:0] opd_right;
   logic signed [COEFF_WIDTH:0] coef_s;
   logic signed [PRD_W-1:0] prd_shift;
   logic signed [ACC_W-1:0] wb_base;
   logic signed [SUM_W-1:0] wb_sum;
   logic signed [ACC_W-1:0] wb_acc;
   logic signed [15:0]      r_int;

   // issue sequencer: one multiply per unstalled cycle, three per frame
   always_comb begin
      phase_in = phase_ff;
      mid_pop  = 1'b0;
      unique case (phase_ff)
         PH_HP: begin
            if (!mid_empty && rsp_room) begin
               mid_pop  = 1'b1;
               phase_in = PH_LEFT;
            end
         end
         PH_LEFT:  phase_in = PH_RIGHT;
         PH_RIGHT: phase_in = PH_HP;
         default:  phase_in = PH_HP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HP;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // multiplier operands for each filter
   always_comb begin
      hp_diff   = {mid_item.samples.front_right_sample[15], mid_item.samples.front_right_sample}
                - {last_in_ff[15], last_in_ff};
      opd_hp    = OPD_W'(hp_acc_ff) + (OPD_W'(hp_diff) <<< S);
      opd_left  = (OPD_W'(item_ff.samples.rear_left_sample) <<< S) - OPD_W'(lpl_acc_ff);
      opd_right = (OPD_W'(item_ff.samples.rear_right_sample) <<< S) - OPD_W'(lpr_acc_ff);

      opd_in               = opd_hp;
      coef_in              = cfg.highpass_coeff;
      opd_tag_in.kind      = OP_NONE;
      opd_tag_in.keep      = item_ff.keep;
      opd_tag_in.chunk_end = item_ff.chunk_end;
      unique case (phase_ff)
         PH_HP: begin
            opd_in               = opd_hp;
            coef_in              = cfg.highpass_coeff;
            opd_tag_in.kind      = mid_pop ? OP_HP : OP_NONE;
            opd_tag_in.keep      = mid_item.keep;
            opd_tag_in.chunk_end = mid_item.chunk_end;
         end
         PH_LEFT: begin
            opd_in          = opd_left;
            coef_in         = cfg.lowpass_coeff;
            opd_tag_in.kind = OP_LEFT;
         end
         PH_RIGHT: begin
            opd_in          = opd_right;
            coef_in         = cfg.lowpass_coeff;
            opd_tag_in.kind = OP_RIGHT;
         end
         default: begin
            opd_tag_in.kind = OP_NONE;
         end
      endcase
   end

   // shared multiplier
   assign coef_s = $signed({1'b0, coef_ff});
   assign prd_in = opd_ff * coef_s;

   always_ff @(posedge clock) begin
      opd_ff  <= opd_in;
      coef_ff <= coef_in;
      prd_ff  <= prd_in;
      if (mid_pop) begin
         item_ff <= mid_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opd_tag_ff.kind      <= OP_NONE;
         opd_tag_ff.keep      <= 1'b0;
         opd_tag_ff.chunk_end <= 1'b0;
         prd_tag_ff.kind      <= OP_NONE;
         prd_tag_ff.keep      <= 1'b0;
         prd_tag_ff.chunk_end <= 1'b0;
      end else begin
         opd_tag_ff <= opd_tag_in;
         prd_tag_ff <= opd_tag_ff;
      end
   end

   // floor shift, accumulate and clamp to the sample range
   always_comb begin
      prd_shift = prd_ff >>> COEFF_FRAC_BITS;
      case (prd_tag_ff.kind)
         OP_LEFT:  wb_base = lpl_acc_ff;
         OP_RIGHT: wb_base = lpr_acc_ff;
         default:  wb_base = '0;
      endcase
      wb_sum = SUM_W'(wb_base) + SUM_W'(prd_shift);
      if (wb_sum > ACC_HI) begin
         wb_acc = ACC_HI[ACC_W-1:0];
      end else if (wb_sum < ACC_LO) begin
         wb_acc = ACC_LO[ACC_W-1:0];
      end else begin
         wb_acc = wb_sum[ACC_W-1:0];
      end
   end

   // filter state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_acc_ff  <= '0;
         lpl_acc_ff <= '0;
         lpr_acc_ff <= '0;
         last_in_ff <= '0;
      end else begin
         if (mid_pop) begin
            last_in_ff <= mid_item.samples.front_right_sample;
         end
         case (prd_tag_ff.kind)
            OP_HP:    hp_acc_ff  <= wb_acc;
            OP_LEFT:  lpl_acc_ff <= wb_acc;
            OP_RIGHT: lpr_acc_ff <= wb_acc;
            default:  ;
         endcase
      end
   end

   // snapshot of high-pass and left outputs once the right filter lands
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= (prd_tag_ff.kind == OP_RIGHT) && prd_tag_ff.keep;
      end
   end

   always_ff @(posedge clock) begin
      if (prd_tag_ff.kind == OP_RIGHT) begin
         fin_chunk_end_ff <= prd_tag_ff.chunk_end;
         fin_hp_ff        <= acc_to_int(hp_acc_ff);
         fin_l_ff         <= acc_to_int(lpl_acc_ff);
      end
   end

   // mix and encode
   always_comb begin
      r_int               = acc_to_int(lpr_acc_ff);
      rsp_item.left_code  = mulaw_encode(sat_add(fin_l_ff, fin_hp_ff));
      rsp_item.right_code = mulaw_encode(sat_add(r_int, fin_hp_ff));
      rsp_item.chunk_end  = fin_chunk_end_ff;
   end

   assign rsp_push = fin_valid_ff;

endmodule

[sv/haptic_audio_filter_mulaw_packer.sv]
`timescale 1ns / 1ps

// Haptic audio filter bank with mu-law packer.
// Input channel: push a frame of three signed 16 bit samples on req_payload
// while req_full is low. Result channel: while rsp_empty is low, rsp_payload
// holds the oldest result (left and right mu-law bytes plus a chunk end
// flag); pulse rsp_pop to take it. Only kept frames (one in every
// decimation frames) give a result; all frames update the filters.
// The single multiplier runs the high-pass and both low-pass products in
// turn, so the engine takes a new frame only once all three products of
// the last are issued. The front takes a frame every cycle while req_full
// is low, into a 4 entry queue, so bursts are absorbed. Each product is
// registered as operand and product, then written back and snapshotted.
// Reset (synchronous, active high) clears filter states, frame and pair
// counters and both queues, and loads the register defaults.
// When the receiver stalls, results collect in a 4 entry output queue; the
// filter engine holds off new frames when fewer than two entries are free,
// then the input queue fills and req_full rises. Nothing is dropped.
// Registers on the csr_ port: 0x0 low-pass alpha, 0x4 high-pass alpha,
// 0x8 decimation, 0xC chunk pairs; write only while idle.
module haptic_audio_filter_mulaw_packer #(
   parameter int COEFF_FRAC_BITS = 16,
   parameter int STATE_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  hafmp_pkg::req_payload_type req_payload,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output hafmp_pkg::rsp_payload_type rsp_payload,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   import hafmp_pkg::*;

   localparam int MID_W = $bits(frame_item_type);
   localparam int RSP_W = $bits(rsp_payload_type);

   cfg_type         cfg_ff, cfg_in;
   reg_index_type   csr_index;
   logic            csr_write;

   logic            mid_push;
   logic            mid_full;
   logic            mid_pop;
   logic            mid_empty;
   frame_item_type  mid_push_item;
   frame_item_type  mid_pop_item;

   logic            rsp_push;
   logic            rsp_full;
   logic            rsp_room;
   rsp_payload_type rsp_push_item;

   // register file
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_LOWPASS_COEFF:  cfg_in.lowpass_coeff  = csr_pwdata[15:0];
            REG_HIGHPASS_COEFF: cfg_in.highpass_coeff = csr_pwdata[15:0];
            REG_DECIMATION:     cfg_in.decimation     = csr_pwdata[6:0];
            REG_CHUNK_PAIRS:    cfg_in.chunk_pairs    = csr_pwdata[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LOWPASS_COEFF:  csr_prdata = {16'd0, cfg_ff.lowpass_coeff};
         REG_HIGHPASS_COEFF: csr_prdata = {16'd0, cfg_ff.highpass_coeff};
         REG_DECIMATION:     csr_prdata = {25'd0, cfg_ff.decimation};
         REG_CHUNK_PAIRS:    csr_prdata = {27'd0, cfg_ff.chunk_pairs};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lowpass_coeff  <= LOWPASS_COEFF_RESET;
         cfg_ff.highpass_coeff <= HIGHPASS_COEFF_RESET;
         cfg_ff.decimation     <= DECIMATION_RESET;
         cfg_ff.chunk_pairs    <= CHUNK_PAIRS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // frame classification
   hafmp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .mid_full    (mid_full),
      .mid_push    (mid_push),
      .mid_item    (mid_push_item)
   );

   // queue between front and filter engine
   hafmp_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_push_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_pop_item),
      .empty     (mid_empty)
   );

   // filter engine and encoder
   assign rsp_room = !rsp_full;

   hafmp_back #(
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .mid_empty (mid_empty),
      .mid_item  (mid_pop_item),
      .mid_pop   (mid_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_push_item)
   );

   // output queue, full rises early so the result in flight always lands
   hafmp_fifo #(
      .WIDTH   (RSP_W),
      .DEPTH   (RSP_DEPTH),
      .RESERVE (RSP_RESERVE)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_push_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_payload),
      .empty     (rsp_empty)
   );

endmodule
